@@ rtl/gtr_pkg.sv @@
// shared types, codes and constants of the two-reaction gillespie step
package gtr_pkg;

  // default sizes
  localparam int COUNT_BITS_DEF     = 16;
  localparam int TIME_FRAC_BITS_DEF = 16;

  // fixed arithmetic sizes
  localparam int PROP_FRAC  = 16;  // fraction bits of the propensities
  localparam int PROP_W     = 63;  // saturated propensity width
  localparam int LOG_FRAC   = 24;  // fraction bits of the log2 result
  localparam int LN_W       = 37;  // width of ln(1/r1) in Q.32
  localparam int NORM_STEPS = 5;   // leading-one search steps over 32 bits
  localparam int IN_W       = 64;
  localparam int OUT_W      = 72;
  localparam int CFG_IDX_W  = 3;

  localparam logic [31:0] LN2_Q32  = 32'd2977044472;
  localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RATE_ONE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_TWO     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FINAL_TIME   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_Z    = 3'd5;

  // register reset values
  localparam logic [31:0] RATE_ONE_RST     = 32'd6554;
  localparam logic [31:0] RATE_TWO_RST     = 32'd131072;
  localparam logic [15:0] SOURCE_COUNT_RST = 16'd500;
  localparam logic [15:0] FINAL_TIME_RST   = 16'd100;
  localparam logic [15:0] INITIAL_Y_RST    = 16'd10;
  localparam logic [15:0] INITIAL_Z_RST    = 16'd0;

  // reaction codes
  localparam logic [1:0] FIRED_NONE = 2'd0;
  localparam logic [1:0] FIRED_ONE  = 2'd1;
  localparam logic [1:0] FIRED_TWO  = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHECK, ST_C1X, ST_YY, ST_A1L, ST_A1H, ST_A1S, ST_A2L, ST_A2H,
    ST_A2S, ST_CHL, ST_CHH, ST_CHS, ST_NRM, ST_SQR, ST_LN, ST_DIV, ST_TIME, ST_EMIT
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_CHECK, OP_C1X, OP_YY, OP_A1L, OP_A1H, OP_A1S, OP_A2L,
    OP_A2H, OP_A2S, OP_CHL, OP_CHH, OP_CHS, OP_NRM, OP_SQR, OP_LN, OP_DIV,
    OP_TIME, OP_EMIT
  } op_e;

  // status from datapath to controller
  typedef struct packed {
    logic begin_run;
    logic finished;
    logic prop_zero;
    logic draw_zero;
    logic out_busy;
  } stat_t;

endpackage

@@ rtl/gtr_ctrl.sv @@
// step sequencer: walks one item through the datapath operations
module gtr_ctrl import gtr_pkg::*; #(
  parameter int TimeFracBits = TIME_FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  stat_t       stat_i,
  output op_e         op_o,
  output logic [2:0]  step_o
);

  localparam int DivW = LN_W + TimeFracBits - PROP_FRAC;
  localparam int CntW = $clog2(DivW > LOG_FRAC ? DivW : LOG_FRAC);

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_CHECK;
      ST_CHECK: begin
        if (stat_i.begin_run || stat_i.finished) state_d = ST_EMIT;
        else state_d = ST_C1X;
      end
      ST_C1X:   state_d = ST_YY;
      ST_YY:    state_d = ST_A1L;
      ST_A1L:   state_d = ST_A1H;
      ST_A1H:   state_d = ST_A1S;
      ST_A1S:   state_d = ST_A2L;
      ST_A2L:   state_d = ST_A2H;
      ST_A2H:   state_d = ST_A2S;
      ST_A2S:   state_d = ST_CHL;
      ST_CHL: begin
        if (stat_i.prop_zero) state_d = ST_EMIT;
        else state_d = ST_CHH;
      end
      ST_CHH:   state_d = ST_CHS;
      ST_CHS: begin
        if (stat_i.draw_zero) state_d = ST_EMIT;
        else state_d = ST_NRM;
      end
      ST_NRM:   if (cnt_q == CntW'(NORM_STEPS - 1)) state_d = ST_SQR;
      ST_SQR:   if (cnt_q == CntW'(LOG_FRAC - 1)) state_d = ST_LN;
      ST_LN:    state_d = ST_DIV;
      ST_DIV:   if (cnt_q == CntW'(DivW - 1)) state_d = ST_TIME;
      ST_TIME:  state_d = ST_EMIT;
      ST_EMIT:  if (!stat_i.out_busy) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // loop counter restarts on every state change
  always_comb begin
    if (state_d != state_q) cnt_d = '0;
    else cnt_d = cnt_q + CntW'(1);
  end

  // operation per state
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    step_o     = cnt_q[2:0];
    case (state_q)
      ST_IDLE:  op_o = in_valid_i ? OP_LOAD : OP_NONE;
      ST_CHECK: op_o = OP_CHECK;
      ST_C1X:   op_o = OP_C1X;
      ST_YY:    op_o = OP_YY;
      ST_A1L:   op_o = OP_A1L;
      ST_A1H:   op_o = OP_A1H;
      ST_A1S:   op_o = OP_A1S;
      ST_A2L:   op_o = OP_A2L;
      ST_A2H:   op_o = OP_A2H;
      ST_A2S:   op_o = OP_A2S;
      ST_CHL:   op_o = OP_CHL;
      ST_CHH:   op_o = OP_CHH;
      ST_CHS:   op_o = OP_CHS;
      ST_NRM:   op_o = OP_NRM;
      ST_SQR:   op_o = OP_SQR;
      ST_LN:    op_o = OP_LN;
      ST_DIV:   op_o = OP_DIV;
      ST_TIME:  op_o = OP_TIME;
      ST_EMIT:  op_o = stat_i.out_busy ? OP_NONE : OP_EMIT;
      default:  op_o = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

@@ rtl/gtr_datapath.sv @@
// registers, shared multiplier, log and divider of the gillespie step
module gtr_datapath import gtr_pkg::*; #(
  parameter int CountBits    = COUNT_BITS_DEF,
  parameter int TimeFracBits = TIME_FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  op_e                  op_i,
  input  logic [2:0]           step_i,
  output stat_t                stat_o,
  input  logic [IN_W-1:0]      in_data_i,
  input  logic                 in_begin_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [OUT_W-1:0]     out_data_o,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  localparam int DivW = LN_W + TimeFracBits - PROP_FRAC;
  localparam int LshW = LN_W + TimeFracBits;
  localparam int SumW = (DivW > 32 ? DivW : 32) + 1;
  localparam int CmpW = (16 + TimeFracBits > 32 ? 16 + TimeFracBits : 32);

  // configuration
  logic [31:0] rate_one_q, rate_two_q;
  logic [15:0] source_q, final_q, init_y_q, init_z_q;

  // run state
  logic [CountBits-1:0] y_q, y_d, z_q, z_d;
  logic [31:0] t_q, t_d;
  logic fin_q, fin_d;
  logic out_valid_q, out_valid_d;

  // item and working registers
  logic [31:0] r1_q, r1_d, r2_q, r2_d;
  logic begin_q, begin_d;
  logic [31:0] snap_t_q, snap_t_d;
  logic [15:0] snap_y_q, snap_y_d, snap_z_q, snap_z_d;
  logic [1:0] fired_q, fired_d;
  logic dead_q, dead_d;
  logic [47:0] cx_q, cx_d;
  logic [PROP_W-1:0] h_q, h_d, a1_q, a1_d;
  logic [63:0] plo_q, plo_d, phi_q, phi_d, a0_q, a0_d;
  logic [31:0] m_q, m_d;
  logic [4:0] k_q, k_d;
  logic [LOG_FRAC-1:0] frac_q, frac_d;
  logic [63:0] rem_q, rem_d;
  logic [DivW-1:0] quo_q, quo_d;
  logic [OUT_W-1:0] res_q, res_d;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  // helper values
  logic [95:0] full;
  logic [PROP_W-1:0] full_sat;
  logic [4:0] sh;
  logic [5:0] rs;
  logic top_zero;
  logic [32:0] sq;
  logic [29:0] lg;
  logic [LshW-1:0] lsh;
  logic [64:0] dtmp;
  logic dge;
  logic [SumW-1:0] tsum;
  logic [31:0] t_new;
  logic [CmpW-1:0] t_lim;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op_i)
      OP_C1X: begin mul_a = rate_one_q;         mul_b = 32'(source_q); end
      OP_YY:  begin mul_a = 32'(y_q);            mul_b = 32'(y_q - CountBits'(1)); end
      OP_A1L: begin mul_a = cx_q[31:0];          mul_b = 32'(y_q); end
      OP_A1H: begin mul_a = 32'(cx_q[47:32]);    mul_b = 32'(y_q); end
      OP_A2L: begin mul_a = h_q[31:0];           mul_b = rate_two_q; end
      OP_A2H: begin mul_a = 32'(h_q[62:32]);     mul_b = rate_two_q; end
      OP_CHL: begin mul_a = a0_q[31:0];          mul_b = r2_q; end
      OP_CHH: begin mul_a = a0_q[63:32];         mul_b = r2_q; end
      OP_SQR: begin mul_a = m_q;                 mul_b = m_q; end
      OP_LN:  begin mul_a = 32'(lg);             mul_b = LN2_Q32; end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    full     = {phi_q, 32'b0} + {32'b0, plo_q};
    full_sat = (|full[95:PROP_W]) ? {PROP_W{1'b1}} : full[PROP_W-1:0];
    sh       = 5'(5'd16 >> step_i);
    rs       = 6'd32 - {1'b0, sh};
    top_zero = ((m_q >> rs) == '0);
    sq       = prod[63:31];
    lg       = {6'd32 - {1'b0, k_q}, {LOG_FRAC{1'b0}}} - 30'(frac_q);
    lsh      = LshW'(prod[LOG_FRAC+LN_W-1:LOG_FRAC]) << TimeFracBits;
    dtmp     = {rem_q, quo_q[DivW-1]};
    dge      = (dtmp >= {1'b0, a0_q});
    tsum     = SumW'(quo_q) + SumW'(t_q);
    t_new    = (tsum > SumW'(TIME_MAX)) ? TIME_MAX : tsum[31:0];
    t_lim    = CmpW'(final_q) << TimeFracBits;
  end

  // operation effects
  always_comb begin
    y_d = y_q; z_d = z_q; t_d = t_q; fin_d = fin_q;
    r1_d = r1_q; r2_d = r2_q; begin_d = begin_q;
    snap_t_d = snap_t_q; snap_y_d = snap_y_q; snap_z_d = snap_z_q;
    fired_d = fired_q; dead_d = dead_q;
    cx_d = cx_q; h_d = h_q; a1_d = a1_q; a0_d = a0_q;
    plo_d = plo_q; phi_d = phi_q;
    m_d = m_q; k_d = k_q; frac_d = frac_q;
    rem_d = rem_q; quo_d = quo_q;
    res_d = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (op_i)
      OP_LOAD: begin
        r1_d     = in_data_i[31:0];
        r2_d     = in_data_i[63:32];
        begin_d  = in_begin_i;
        snap_t_d = t_q;
        snap_y_d = 16'(y_q);
        snap_z_d = 16'(z_q);
        fired_d  = FIRED_NONE;
        dead_d   = 1'b0;
      end
      OP_CHECK: begin
        if (begin_q) begin
          y_d   = CountBits'(init_y_q);
          z_d   = CountBits'(init_z_q);
          t_d   = '0;
          fin_d = 1'b0;
        end
      end
      OP_C1X: cx_d = prod[47:0];
      OP_YY:  h_d = prod[63:1];
      OP_A1L, OP_A2L, OP_CHL: begin
        plo_d = prod;
        // no reaction can fire
        if (op_i == OP_CHL && a0_q == '0) begin
          fin_d  = 1'b1;
          dead_d = 1'b1;
        end
      end
      OP_A1H, OP_A2H, OP_CHH: phi_d = prod;
      OP_A1S: a1_d = full_sat;
      OP_A2S: a0_d = {1'b0, a1_q} + {1'b0, full_sat};
      OP_CHS: begin
        // reaction one when r2*a0 <= a1*2^32
        if (full <= {1'b0, a1_q, 32'b0}) begin
          y_d     = (y_q == '1) ? y_q : y_q + CountBits'(1);
          fired_d = FIRED_ONE;
        end else begin
          y_d     = (y_q >= CountBits'(2)) ? y_q - CountBits'(2) : '0;
          z_d     = (z_q == '1) ? z_q : z_q + CountBits'(1);
          fired_d = FIRED_TWO;
        end
        // zero time draw: infinite step
        if (r1_q == '0) begin
          t_d   = TIME_MAX;
          fin_d = 1'b1;
        end
        m_d = r1_q;
        k_d = 5'd31;
      end
      OP_NRM: begin
        if (top_zero) begin
          m_d = m_q << sh;
          k_d = k_q - sh;
        end
      end
      OP_SQR: begin
        m_d    = sq[32] ? sq[32:1] : sq[31:0];
        frac_d = {frac_q[LOG_FRAC-2:0], sq[32]};
      end
      OP_LN: begin
        rem_d = '0;
        quo_d = lsh[LshW-1:PROP_FRAC];
      end
      OP_DIV: begin
        rem_d = dge ? 64'(dtmp - {1'b0, a0_q}) : dtmp[63:0];
        quo_d = {quo_q[DivW-2:0], dge};
      end
      OP_TIME: begin
        t_d = t_new;
        if (CmpW'(t_new) > t_lim || t_new == TIME_MAX) fin_d = 1'b1;
      end
      OP_EMIT: begin
        out_valid_d = 1'b1;
        if (begin_q) res_d = {4'b0, 1'b0, 1'b0, FIRED_NONE, 16'(z_q), 16'(y_q), 32'b0};
        else res_d = {4'b0, dead_q, fin_q, fired_q, snap_z_q, snap_y_q, snap_t_q};
      end
      default: ;
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_one_q  <= RATE_ONE_RST;
      rate_two_q  <= RATE_TWO_RST;
      source_q    <= SOURCE_COUNT_RST;
      final_q     <= FINAL_TIME_RST;
      init_y_q    <= INITIAL_Y_RST;
      init_z_q    <= INITIAL_Z_RST;
      y_q         <= CountBits'(INITIAL_Y_RST);
      z_q         <= CountBits'(INITIAL_Z_RST);
      t_q         <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      y_q         <= y_d;
      z_q         <= z_d;
      t_q         <= t_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_RATE_ONE:     rate_one_q <= cfg_data_i;
          REG_RATE_TWO:     rate_two_q <= cfg_data_i;
          REG_SOURCE_COUNT: source_q   <= cfg_data_i[15:0];
          REG_FINAL_TIME:   final_q    <= cfg_data_i[15:0];
          REG_INITIAL_Y:    init_y_q   <= cfg_data_i[15:0];
          REG_INITIAL_Z:    init_z_q   <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  // working payload
  always_ff @(posedge clk_i) begin
    r1_q <= r1_d; r2_q <= r2_d; begin_q <= begin_d;
    snap_t_q <= snap_t_d; snap_y_q <= snap_y_d; snap_z_q <= snap_z_d;
    fired_q <= fired_d; dead_q <= dead_d;
    cx_q <= cx_d; h_q <= h_d; a1_q <= a1_d; a0_q <= a0_d;
    plo_q <= plo_d; phi_q <= phi_d;
    m_q <= m_d; k_q <= k_d; frac_q <= frac_d;
    rem_q <= rem_d; quo_q <= quo_d;
    res_q <= res_d;
  end

  assign stat_o.begin_run = begin_q;
  assign stat_o.finished  = fin_q;
  assign stat_o.prop_zero = (a0_q == '0);
  assign stat_o.draw_zero = (r1_q == '0);
  assign stat_o.out_busy  = out_valid_q && !out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign out_data_o       = res_q;

endmodule

@@ rtl/gillespie_two_reaction_step.sv @@
// top level of the two-reaction gillespie direct-method step
//
// Input stream: one transaction per step; tdata carries draws r1 and r2,
// tuser the begin flag that reloads Y, Z from the initial registers and
// clears time. Output stream: exactly one transaction per input with the
// time and counts before the step, the reaction fired and the end flags.
// Configuration: index/data write channel, always ready; write only idle.
// Path from input transaction to output valid: a begin or an ended run
// goes from the check straight to emit; a dead end leaves before the
// reaction choice, a zero time draw after it; a full step goes on through
// the log squaring loop, the ln scaling, the one-bit-per-cycle divider
// and the time update. One item is in work at a time; input is ready
// again once the result is in the output register, so the next item
// starts while it waits. Reset loads the register defaults, Y and Z from
// initial_y/initial_z, time zero, run not over. A stalled receiver holds
// the result; a second finished result waits inside until the register
// frees.
module gillespie_two_reaction_step import gtr_pkg::*; #(
  parameter int CountBits    = COUNT_BITS_DEF,
  parameter int TimeFracBits = TIME_FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [31:0] draw_time, [63:32] draw_choice
  input  logic [IN_W-1:0]      s_axis_tdata,
  // [0] begin_run
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [31:0] sample_time, [47:32] y_count, [63:48] z_count, [65:64] fired,
  // [66] run_over, [67] dead_end, [71:68] zero
  output logic [OUT_W-1:0]     m_axis_tdata,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  op_e        op;
  logic [2:0] step;
  stat_t      stat;

  assign cfg_ready_o = 1'b1;

  // sequencer
  gtr_ctrl #(
    .TimeFracBits(TimeFracBits)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .op_o       (op),
    .step_o     (step)
  );

  // arithmetic and state
  gtr_datapath #(
    .CountBits   (CountBits),
    .TimeFracBits(TimeFracBits)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .step_i      (step),
    .stat_o      (stat),
    .in_data_i   (s_axis_tdata),
    .in_begin_i  (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // one item in work at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an item is in work");

  // a dead end always ends the run and fires nothing
  a_dead_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[67] |-> m_axis_tdata[66] &&
      (m_axis_tdata[65:64] == FIRED_NONE))
    else $error("dead end without run over");

  // no reaction code beyond two
  a_fired_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[65:64] == FIRED_NONE) ||
      (m_axis_tdata[65:64] == FIRED_ONE) || (m_axis_tdata[65:64] == FIRED_TWO))
    else $error("invalid fired code");

endmodule
